// ===== rtl/core/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, message codes and capture geometry of the feed decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int CAPTURE_BYTES = 44;
  localparam int CAP_OFF_W     = $clog2(CAPTURE_BYTES);
  localparam int KIND_COUNT    = 9;

  typedef enum logic [3:0] {
    KIND_ADD            = 4'd0,
    KIND_DELETE         = 4'd1,
    KIND_REPLACE        = 4'd2,
    KIND_EXECUTED       = 4'd3,
    KIND_CANCEL         = 4'd4,
    KIND_DIRECTORY      = 4'd5,
    KIND_ADD_MPID       = 4'd6,
    KIND_EXECUTED_PRICE = 4'd7,
    KIND_TRADE          = 4'd8
  } kind_t;

  localparam logic [7:0] TYPE_ADD            = 8'h41;  // 'A'
  localparam logic [7:0] TYPE_DELETE         = 8'h44;  // 'D'
  localparam logic [7:0] TYPE_REPLACE        = 8'h55;  // 'U'
  localparam logic [7:0] TYPE_EXECUTED       = 8'h45;  // 'E'
  localparam logic [7:0] TYPE_CANCEL         = 8'h58;  // 'X'
  localparam logic [7:0] TYPE_DIRECTORY      = 8'h52;  // 'R'
  localparam logic [7:0] TYPE_ADD_MPID       = 8'h46;  // 'F'
  localparam logic [7:0] TYPE_EXECUTED_PRICE = 8'h43;  // 'C'
  localparam logic [7:0] TYPE_TRADE          = 8'h50;  // 'P'
  localparam logic [7:0] ASCII_SPACE         = 8'h20;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_dec_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  locate;
    logic [47:0]  etime;
    logic [63:0]  ref1;
    logic [63:0]  ref2;
    logic [31:0]  shares;
    logic [31:0]  price;
    logic [7:0]   side;
    logic [7:0]   status;
    logic [63:0]  symbol;
    logic [31:0]  mpid;
  } msg_rec_t;

  function automatic kind_dec_t decode_type(input logic [7:0] t);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_ADD;
    unique case (t)
      TYPE_ADD:            d.kind = KIND_ADD;
      TYPE_DELETE:         d.kind = KIND_DELETE;
      TYPE_REPLACE:        d.kind = KIND_REPLACE;
      TYPE_EXECUTED:       d.kind = KIND_EXECUTED;
      TYPE_CANCEL:         d.kind = KIND_CANCEL;
      TYPE_DIRECTORY:      d.kind = KIND_DIRECTORY;
      TYPE_ADD_MPID:       d.kind = KIND_ADD_MPID;
      TYPE_EXECUTED_PRICE: d.kind = KIND_EXECUTED_PRICE;
      TYPE_TRADE:          d.kind = KIND_TRADE;
      default:             d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front
// Frame tracker: strips length prefixes, routes body bytes into message
// fields by type and offset, and pushes one record per enabled message.
// ----------------------------------------------------------------------------
module mfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [8:0]      cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            q_full,
  output logic            push,
  output mfd_pkg::msg_rec_t push_rec
);
  import mfd_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  phase_t                 phase;
  logic [8:0]             type_enable;
  logic [15:0]            body_len;
  logic [15:0]            body_pos;
  logic                   kind_hit;
  kind_t                  kind;
  msg_rec_t               rec;
  msg_rec_t               rec_next;
  kind_dec_t              cur;
  logic                   accept;
  logic                   last;
  logic                   cap;
  logic [CAP_OFF_W-1:0]   off;

  function automatic logic in_rng(input logic [CAP_OFF_W-1:0] o, input int lo, input int hi);
    return (o >= CAP_OFF_W'(lo)) && (o <= CAP_OFF_W'(hi));
  endfunction

  function automatic logic [2:0] lane(input logic [CAP_OFF_W-1:0] o, input int hi);
    return 3'(CAP_OFF_W'(hi) - o);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = (body_pos == body_len - 16'd1);
  assign cap      = (body_pos < 16'(CAPTURE_BYTES));
  assign off      = body_pos[CAP_OFF_W-1:0];

  always_comb begin
    if (body_pos == 16'd0) begin
      cur = decode_type(data_byte);
    end else begin
      cur.hit  = kind_hit;
      cur.kind = kind;
    end
  end

  always_comb begin
    rec_next      = rec;
    rec_next.kind = cur.kind;
    if (cap) begin
      if (in_rng(off, 1, 2))  rec_next.locate[8*lane(off, 2) +: 8] = data_byte;
      if (in_rng(off, 5, 10)) rec_next.etime[8*lane(off, 10) +: 8] = data_byte;
      if (cur.kind == KIND_DIRECTORY) begin
        if (in_rng(off, 11, 18)) rec_next.symbol[8*lane(off, 18) +: 8] = data_byte;
      end else begin
        if (in_rng(off, 11, 18)) rec_next.ref1[8*lane(off, 18) +: 8] = data_byte;
      end
      case (cur.kind)
        KIND_ADD, KIND_ADD_MPID, KIND_TRADE: begin
          if (in_rng(off, 19, 19)) rec_next.side = data_byte;
          if (in_rng(off, 20, 23)) rec_next.shares[8*lane(off, 23) +: 8] = data_byte;
          if (in_rng(off, 24, 31)) rec_next.symbol[8*lane(off, 31) +: 8] = data_byte;
          if (in_rng(off, 32, 35)) rec_next.price[8*lane(off, 35) +: 8] = data_byte;
          if (cur.kind == KIND_ADD_MPID && in_rng(off, 36, 39)) begin
            rec_next.mpid[8*lane(off, 39) +: 8] = data_byte;
          end
          if (cur.kind == KIND_TRADE && in_rng(off, 36, 43)) begin
            rec_next.ref2[8*lane(off, 43) +: 8] = data_byte;
          end
        end
        KIND_REPLACE: begin
          if (in_rng(off, 19, 26)) rec_next.ref2[8*lane(off, 26) +: 8] = data_byte;
          if (in_rng(off, 27, 30)) rec_next.shares[8*lane(off, 30) +: 8] = data_byte;
          if (in_rng(off, 31, 34)) rec_next.price[8*lane(off, 34) +: 8] = data_byte;
        end
        KIND_EXECUTED, KIND_EXECUTED_PRICE: begin
          if (in_rng(off, 19, 22)) rec_next.shares[8*lane(off, 22) +: 8] = data_byte;
          if (in_rng(off, 23, 30)) rec_next.ref2[8*lane(off, 30) +: 8] = data_byte;
          if (cur.kind == KIND_EXECUTED_PRICE) begin
            if (in_rng(off, 31, 31)) rec_next.side = data_byte;
            if (in_rng(off, 32, 35)) rec_next.price[8*lane(off, 35) +: 8] = data_byte;
          end
        end
        KIND_CANCEL: begin
          if (in_rng(off, 19, 22)) rec_next.shares[8*lane(off, 22) +: 8] = data_byte;
        end
        KIND_DIRECTORY: begin
          if (in_rng(off, 19, 19)) rec_next.side = data_byte;
          if (in_rng(off, 20, 20)) rec_next.status = data_byte;
          if (in_rng(off, 21, 24)) rec_next.shares[8*lane(off, 24) +: 8] = data_byte;
        end
        default: begin
        end
      endcase
    end
  end

  assign push     = accept && (phase == PH_BODY) && last && cur.hit &&
                    type_enable[cur.kind];
  assign push_rec = rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEN_HI;
      type_enable <= 9'h1FF;
      body_len    <= 16'd0;
      body_pos    <= 16'd0;
      kind_hit    <= 1'b0;
      kind        <= KIND_ADD;
    end else begin
      if (cfg_wr_en) begin
        type_enable <= cfg_wr_data;
      end
      if (accept) begin
        unique case (phase)
          PH_LEN_HI: begin
            body_len <= {data_byte, 8'd0};
            phase    <= PH_LEN_LO;
          end
          PH_LEN_LO: begin
            body_len <= {body_len[15:8], data_byte};
            body_pos <= 16'd0;
            if ({body_len[15:8], data_byte} == 16'd0) begin
              phase <= PH_LEN_HI;
            end else begin
              phase <= PH_BODY;
            end
          end
          PH_BODY: begin
            kind_hit <= cur.hit;
            kind     <= cur.kind;
            if (last) begin
              body_pos <= 16'd0;
              phase    <= PH_LEN_HI;
            end else begin
              body_pos <= body_pos + 16'd1;
            end
          end
          default: phase <= PH_LEN_HI;
        endcase
      end
    end
  end

  // Field registers: clear at each body start, otherwise take routed bytes.
  always_ff @(posedge clk) begin
    if (accept && phase == PH_LEN_LO) begin
      rec <= '0;
    end else if (accept && phase == PH_BODY) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== rtl/core/mfd_queue.sv =====
// ----------------------------------------------------------------------------
// mfd_queue
// Two-entry record queue between the frame tracker and the output stage.
// ----------------------------------------------------------------------------
module mfd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfd_pkg::msg_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mfd_pkg::msg_rec_t head_rec
);
  import mfd_pkg::*;

  msg_rec_t    mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back
// Output stage: trims trailing spaces from the symbol and holds the result
// transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module mfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  mfd_pkg::msg_rec_t head_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mfd_pkg::msg_rec_t out_rec
);
  import mfd_pkg::*;

  msg_rec_t trimmed;

  function automatic logic [63:0] trim_symbol(input logic [63:0] s);
    logic [63:0] r;
    logic        tail;
    r    = s;
    tail = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (tail && r[8*i +: 8] == ASCII_SPACE) begin
        r[8*i +: 8] = 8'd0;
      end else begin
        tail = 1'b0;
      end
    end
    return r;
  endfunction

  always_comb begin
    trimmed        = head_rec;
    trimmed.symbol = trim_symbol(head_rec.symbol);
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= trimmed;
    end
  end

endmodule

// ===== rtl/core/market_feed_message_decoder.sv =====
// ----------------------------------------------------------------------------
// market_feed_message_decoder
// Length-framed feed message decoder with per-kind result enables.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle on in_valid/in_ready. Each byte only
// advances the frame counters and lands in at most one field register, so
// the input sustains one byte per clock; a decoded result is pushed with
// the last body byte into a two-entry queue, then into an output register
// held until out_ready is high. The input stalls only when both queue
// entries are taken. Write type_enable only while no frame is in flight.
module market_feed_message_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [3:0]   message_kind,
  output logic [15:0]  locate_code,
  output logic [47:0]  event_time,
  output logic [63:0]  order_reference,
  output logic [63:0]  second_reference,
  output logic [31:0]  share_count,
  output logic [31:0]  price_value,
  output logic [7:0]   side_or_category,
  output logic [7:0]   status_byte,
  output logic [63:0]  stock_symbol,
  output logic [31:0]  participant_id
);
  import mfd_pkg::*;

  logic     q_full;
  logic     push;
  msg_rec_t push_rec;
  logic     pop;
  logic     head_valid;
  msg_rec_t head_rec;
  msg_rec_t out_rec;

  mfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  mfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rec    (out_rec)
  );

  assign message_kind     = out_rec.kind;
  assign locate_code      = out_rec.locate;
  assign event_time       = out_rec.etime;
  assign order_reference  = out_rec.ref1;
  assign second_reference = out_rec.ref2;
  assign share_count      = out_rec.shares;
  assign price_value      = out_rec.price;
  assign side_or_category = out_rec.side;
  assign status_byte      = out_rec.status;
  assign stock_symbol     = out_rec.symbol;
  assign participant_id   = out_rec.mpid;

endmodule

// ===== rtl/core/mfd_checker.sv =====
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks on the decoder result transaction.
// ----------------------------------------------------------------------------
module mfd_checker (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input logic [3:0]   message_kind,
  input logic [63:0]  order_reference,
  input logic [7:0]   status_byte,
  input logic [31:0]  participant_id
);
  import mfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(message_kind))
    else $error("result transaction dropped or changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> message_kind <= 4'(KIND_COUNT - 1))
    else $error("message kind out of range");

  a_status_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_kind != KIND_DIRECTORY |-> status_byte == 8'd0)
    else $error("status byte set outside directory message");

  a_mpid_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_kind != KIND_ADD_MPID |-> participant_id == 32'd0)
    else $error("participant id set outside add_mpid message");

  a_dir_noref: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_kind == KIND_DIRECTORY |-> order_reference == 64'd0)
    else $error("order reference set on directory message");

endmodule

bind market_feed_message_decoder mfd_checker u_mfd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .message_kind    (message_kind),
  .order_reference (order_reference),
  .status_byte     (status_byte),
  .participant_id  (participant_id)
);
